// ----- sv/csv3_pkg.sv -----
// Package for the 3x3 Cramer solver: shared widths.
// No dependencies.
package csv3_pkg;
    localparam int DataW = 32;
    localparam int DetW  = 99;
    localparam int QW    = 34;
    localparam int NumW  = DetW + 16;
    localparam int InW   = 12 * DataW;
    localparam int OutW  = 3 * DataW + 8;
endpackage

// ----- sv/cramer_solver_3x3.sv -----
// Top level of the 3x3 Cramer solver.
// Depends on csv3_pkg.
//
// Accepts one word per cycle while the output is not stalled, and returns one solution word
// per input word. The pipeline holds four stages of products and sums, a magnitude stage,
// QW + 1 division stages (a load stage, then one quotient bit per stage) and an output
// register; the division stages make up most of it. A stall freezes the whole pipeline.
module cramer_solver_3x3
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // a_r0c0..a_r2c2, rhs_0, rhs_1, rhs_2
    input  logic [csv3_pkg::InW-1:0]       s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // sol_0, sol_1, sol_2, singular, zero pad
    output logic [csv3_pkg::OutW-1:0]      m_tdata
);
    import csv3_pkg::*;

    localparam int NS = 7 + QW;
    localparam int PW = 2 * DataW + 1;

    logic                      adv;
    logic [NS-1:0]             vld_reg;
    logic signed [DataW-1:0]   e [12];

    logic signed [PW-1:0]      p1_reg [4][6];
    logic signed [DataW-1:0]   c1_reg [4][6];
    logic signed [PW-1:0]      pl2_reg [4][6];
    logic signed [PW-1:0]      ph2_reg [4][6];
    logic signed [DetW-1:0]    t2_reg [4][6];
    logic signed [DetW-1:0]    d3_reg [4];
    logic                      sg4_reg;
    logic                      neg4_reg [3];
    logic [NumW-1:0]           n4_reg [3];
    logic [DetW-1:0]           den4_reg;

    logic [NumW-1:0]           rem_reg [QW+1][3];
    logic [QW-1:0]             q_reg [QW+1][3];
    logic [DetW-1:0]           den_reg [QW+1];
    logic                      neg_reg [QW+1][3];
    logic                      sg_reg [QW+1];
    logic [OutW-1:0]           out_reg;
    logic [OutW-1:0]           out_next;

    assign adv      = !vld_reg[NS-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = out_reg;

    always_comb
    begin
        for (int i = 0; i < 12; i++)
        begin
            e[i] = s_tdata[i*DataW +: DataW];
        end
    end

    function automatic logic signed [DataW-1:0] el(input int k, input int r, input int c);
        logic signed [DataW-1:0] v;
        v = (c == k) ? e[9+r] : e[r*3+c];
        return v;
    endfunction

    always_comb
    begin
        out_next = '0;
        out_next[3*DataW] = sg_reg[QW];
        for (int k = 0; k < 3; k++)
        begin
            if (sg_reg[QW])
            begin
                out_next[k*DataW +: DataW] = '0;
            end
            else if (neg_reg[QW][k])
            begin
                out_next[k*DataW +: DataW] = (q_reg[QW][k] >= QW'(34'h80000000))
                    ? 32'h80000000 : DataW'(-q_reg[QW][k]);
            end
            else
            begin
                out_next[k*DataW +: DataW] = (q_reg[QW][k] >= QW'(34'h7FFFFFFF))
                    ? 32'h7FFFFFFF : q_reg[QW][k][DataW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                p1_reg[k][0] <= el(k,0,0) * el(k,1,1); c1_reg[k][0] <= el(k,2,2);
                p1_reg[k][1] <= el(k,0,1) * el(k,1,2); c1_reg[k][1] <= el(k,2,0);
                p1_reg[k][2] <= el(k,0,2) * el(k,1,0); c1_reg[k][2] <= el(k,2,1);
                p1_reg[k][3] <= -(el(k,0,0) * el(k,1,2)); c1_reg[k][3] <= el(k,2,1);
                p1_reg[k][4] <= -(el(k,0,1) * el(k,1,0)); c1_reg[k][4] <= el(k,2,2);
                p1_reg[k][5] <= -(el(k,0,2) * el(k,1,1)); c1_reg[k][5] <= el(k,2,0);
                // split the wide pair product into a low unsigned and a high signed half
                for (int j = 0; j < 6; j++)
                begin
                    pl2_reg[k][j] <= $signed({1'b0, p1_reg[k][j][DataW-1:0]})
                                   * c1_reg[k][j];
                    ph2_reg[k][j] <= $signed(p1_reg[k][j][PW-1:DataW]) * c1_reg[k][j];
                    t2_reg[k][j]  <= ({{(DetW-PW){ph2_reg[k][j][PW-1]}}, ph2_reg[k][j]}
                                      << DataW)
                                   + {{(DetW-PW){pl2_reg[k][j][PW-1]}}, pl2_reg[k][j]};
                end
                d3_reg[k] <= t2_reg[k][0] + t2_reg[k][1] + t2_reg[k][2]
                           + t2_reg[k][3] + t2_reg[k][4] + t2_reg[k][5];
            end
            sg4_reg  <= (d3_reg[3] == '0);
            den4_reg <= d3_reg[3][DetW-1] ? DetW'(-d3_reg[3]) : DetW'(d3_reg[3]);
            for (int k = 0; k < 3; k++)
            begin
                neg4_reg[k] <= d3_reg[k][DetW-1] ^ d3_reg[3][DetW-1];
                n4_reg[k]   <= {(d3_reg[k][DetW-1] ? DetW'(-d3_reg[k])
                                                   : DetW'(d3_reg[k])), 16'h0};
            end
            // restoring division, one quotient bit per stage (low QW bits only)
            den_reg[0] <= den4_reg;
            sg_reg[0]  <= sg4_reg;
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[0][k] <= n4_reg[k];
                q_reg[0][k]   <= '0;
                neg_reg[0][k] <= neg4_reg[k];
            end
            for (int s = 0; s < QW; s++)
            begin
                den_reg[s+1] <= den_reg[s];
                sg_reg[s+1]  <= sg_reg[s];
                for (int k = 0; k < 3; k++)
                begin
                    neg_reg[s+1][k] <= neg_reg[s][k];
                    if ((rem_reg[s][k] >> (QW-1-s)) >= {16'h0, den_reg[s]})
                    begin
                        rem_reg[s+1][k] <= rem_reg[s][k]
                                         - ({16'h0, den_reg[s]} << (QW-1-s));
                        q_reg[s+1][k]   <= {q_reg[s][k][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s+1][k] <= rem_reg[s][k];
                        q_reg[s+1][k]   <= {q_reg[s][k][QW-2:0], 1'b0};
                    end
                end
            end
            out_reg <= out_next;
        end
    end
endmodule

// ----- test/cramer_solver_3x3_tb.sv -----
// Testbench for cramer_solver_3x3: drives 3x3 systems in Q16.16 and checks each
// solution word against an exact wide-integer Cramer's-rule predictor.
// Depends on csv3_pkg and cramer_solver_3x3.
module cramer_solver_3x3_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csv3_pkg::*;

    typedef logic signed [31:0] q16_t;

    typedef struct {
        q16_t a [3][3];
        q16_t rhs [3];
    } system_t;

    typedef struct {
        q16_t sol [3];
        logic singular;
    } solution_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [InW-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OutW-1:0] m_tdata;

    solution_t expected_q[$];
    int mismatches;
    int solved;
    int singular_seen;
    int saturated_seen;
    int burst_left;
    bit rx_stall_on;

    cramer_solver_3x3 dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("Timeout");
        $display("Some tests failed");
        $finish;
    end

    function automatic logic signed [127:0] det3(input q16_t m [3][3]);
        logic signed [127:0] d;
        d = 128'(m[0][0]) * m[1][1] * m[2][2]
          + 128'(m[0][1]) * m[1][2] * m[2][0]
          + 128'(m[0][2]) * m[1][0] * m[2][1]
          - 128'(m[0][0]) * m[1][2] * m[2][1]
          - 128'(m[0][1]) * m[1][0] * m[2][2]
          - 128'(m[0][2]) * m[1][1] * m[2][0];
        return d;
    endfunction

    function automatic solution_t solve_cramer(input system_t s);
        solution_t r;
        q16_t t [3][3];
        logic signed [127:0] den;
        logic signed [127:0] num;
        logic signed [159:0] q;
        den = det3(s.a);
        r.singular = (den == 0);
        for (int k = 0; k < 3; k++)
        begin
            r.sol[k] = '0;
            if (!r.singular)
            begin
                t = s.a;
                for (int i = 0; i < 3; i++)
                    t[i][k] = s.rhs[i];
                num = det3(t);
                q = (160'(num) <<< 16) / 160'(den);
                if (q > 160'sh7FFFFFFF)
                    r.sol[k] = 32'sh7FFFFFFF;
                else if (q < -160'sh80000000)
                    r.sol[k] = 32'sh80000000;
                else
                    r.sol[k] = q[31:0];
            end
        end
        return r;
    endfunction

    function automatic q16_t rand_elem(input int mode);
        case (mode)
            0: return q16_t'($urandom);
            1: return q16_t'($urandom_range(0, 32'h60000)) - 32'sh30000;
            2: return q16_t'($urandom_range(0, 8)) <<< 16;
            default: return q16_t'($urandom_range(0, 32'h1FFFF)) - 32'sh10000;
        endcase
    endfunction

    task automatic send_system(input system_t s);
        logic [InW-1:0] w;
        for (int i = 0; i < 9; i++)
            w[i*32 +: 32] = s.a[i/3][i%3];
        for (int i = 0; i < 3; i++)
            w[(9+i)*32 +: 32] = s.rhs[i];
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= w;
        expected_q.push_back(solve_cramer(s));
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_ident(input q16_t scale, input q16_t b0, input q16_t b1, input q16_t b2);
        system_t s;
        foreach (s.a[i, j])
            s.a[i][j] = (i == j) ? scale : '0;
        s.rhs = '{b0, b1, b2};
        send_system(s);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        system_t s;
        send_ident(32'sh10000, 32'sh10000, -32'sh10000, 32'sh7FFFFFFF);
        send_ident(32'sh10000, 32'sh80000000, 32'sh0, 32'sh1);
        send_ident(32'sh1, 32'sh7FFFFFFF, 32'sh80000000, -32'sh1);
        send_ident(-32'sh1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh1);
        send_ident(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh3);
        send_ident(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, -32'sh3);
        send_ident(32'sh30000, 32'sh10000, 32'sh20000, -32'sh10000);
        send_ident(32'sh0, 32'sh10000, 32'sh10000, 32'sh10000);
        foreach (s.a[i, j])
            s.a[i][j] = 32'sh80000000;
        s.rhs = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        send_system(s);
        foreach (s.a[i, j])
            s.a[i][j] = 32'sh7FFFFFFF;
        s.rhs = '{32'sh7FFFFFFF, 32'sh0, 32'sh80000000};
        send_system(s);
        // extreme entries, nonsingular
        foreach (s.a[i, j])
            s.a[i][j] = (i == j) ? 32'sh80000000 : 32'sh7FFFFFFF;
        send_system(s);
        foreach (s.a[i, j])
            s.a[i][j] = (i == j) ? 32'sh7FFFFFFF : 32'sh80000000;
        s.rhs = '{32'sh1, 32'sh7FFFFFFF, 32'sh80000000};
        send_system(s);
        // rank-deficient: row 2 = row 0 + row 1
        for (int j = 0; j < 3; j++)
        begin
            s.a[0][j] = rand_elem(1);
            s.a[1][j] = rand_elem(1);
            s.a[2][j] = s.a[0][j] + s.a[1][j];
        end
        send_system(s);
        // a negated permutation matrix
        foreach (s.a[i, j])
            s.a[i][j] = (j == (i + 1) % 3) ? -32'sh10000 : '0;
        s.rhs = '{32'sh12345, -32'sh54321, 32'sh7FFFFFFF};
        send_system(s);
        // tiny determinant forces saturation
        send_ident(32'sh100, 32'sh7FFFFFFF, 32'sh80000000, 32'sh10000);
        drain();
    endtask

    task automatic test_random(input int count);
        system_t s;
        int mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 3);
            foreach (s.a[i, j])
                s.a[i][j] = rand_elem(mode);
            foreach (s.rhs[i])
                s.rhs[i] = rand_elem($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0)
                for (int i = 0; i < 3; i++)
                    s.a[i][2] = s.a[i][$urandom_range(0, 1)];
            send_system(s);
            if (n == count / 2)
                drain();
        end
        drain();
    endtask

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall_on <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                rx_stall_on <= ~rx_stall_on;
            m_tready <= rx_stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        solution_t exp_sol;
        logic [31:0] got [3];
        logic got_sing;
        if (rst_n && m_tvalid && m_tready)
        begin
            for (int k = 0; k < 3; k++)
                got[k] = m_tdata[k*32 +: 32];
            got_sing = m_tdata[96];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected solution word %h", m_tdata);
            end
            else
            begin
                exp_sol = expected_q.pop_front();
                solved++;
                if (exp_sol.singular)
                    singular_seen++;
                for (int k = 0; k < 3; k++)
                    if (exp_sol.sol[k] == 32'sh7FFFFFFF || exp_sol.sol[k] == 32'sh80000000)
                        saturated_seen++;
                if (got[0] != exp_sol.sol[0] || got[1] != exp_sol.sol[1]
                    || got[2] != exp_sol.sol[2] || got_sing != exp_sol.singular)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h %h %h sing %b, got %h %h %h sing %b",
                                 exp_sol.sol[0], exp_sol.sol[1], exp_sol.sol[2],
                                 exp_sol.singular, got[0], got[1], got[2], got_sing);
                end
            end
        end
    end

    initial
    begin
        mismatches = 0;
        solved = 0;
        singular_seen = 0;
        saturated_seen = 0;
        burst_left = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1000);
        repeat (60) @(posedge clk);
        $display("Checked %0d solutions: %0d singular, %0d saturated elements.",
                 solved, singular_seen, saturated_seen);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- files.f -----
sv/csv3_pkg.sv
sv/cramer_solver_3x3.sv
test/cramer_solver_3x3_tb.sv
